// File: hw/rtl/cfip_pkg.sv
package cfip_pkg;

    localparam int EXP_WIDTH = 64;

    localparam int SIG_W  = 50;
    localparam int EXPI_W = 12;

    localparam logic [31:0] FP_ONE    = 32'h3F80_0000;
    localparam logic [31:0] FP_ZERO   = 32'h0000_0000;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    localparam logic [5:0] DIV_LAST = 6'd48;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_DIV
    } fp_op_t;

    typedef enum logic [2:0] {
        R_A,
        R_B,
        R_RE,
        R_IM,
        R_P0,
        R_P1,
        R_P2,
        R_P3
    } reg_sel_t;

    typedef struct packed {
        fp_op_t   op;
        reg_sel_t src_a;
        reg_sel_t src_b;
        reg_sel_t dst;
        logic     neg_a;
    } uop_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic shift;
        logic capture;
        uop_t uop;
    } cmd_t;

    typedef struct packed {
        logic fpu_done;
        logic mag_zero;
        logic mag_lsb;
        logic mag_one;
        logic neg;
    } stat_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_START,
        C_BIT,
        C_SQ,
        C_ISSUE,
        C_WAIT,
        C_OUT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_ALIGN,
        F_PRENORM,
        F_DIV,
        F_NORM,
        F_DONE
    } fpu_state_t;

    // reciprocal, multiply into accumulator, square
    localparam logic [3:0] RECIP_START = 4'd0;
    localparam logic [3:0] RECIP_END   = 4'd4;
    localparam logic [3:0] MUL_START   = 4'd5;
    localparam logic [3:0] MUL_END     = 4'd10;
    localparam logic [3:0] SQ_START    = 4'd11;
    localparam logic [3:0] SQ_END      = 4'd15;

    localparam uop_t UOP_TABLE [16] = '{
        '{OP_MUL, R_A,  R_A,  R_P0, 1'b0},
        '{OP_MUL, R_B,  R_B,  R_P1, 1'b0},
        '{OP_ADD, R_P0, R_P1, R_P2, 1'b0},
        '{OP_DIV, R_A,  R_P2, R_A,  1'b0},
        '{OP_DIV, R_B,  R_P2, R_B,  1'b1},
        '{OP_MUL, R_RE, R_A,  R_P0, 1'b0},
        '{OP_MUL, R_IM, R_B,  R_P1, 1'b0},
        '{OP_MUL, R_IM, R_A,  R_P2, 1'b0},
        '{OP_MUL, R_RE, R_B,  R_P3, 1'b0},
        '{OP_SUB, R_P0, R_P1, R_RE, 1'b0},
        '{OP_ADD, R_P2, R_P3, R_IM, 1'b0},
        '{OP_MUL, R_A,  R_A,  R_P0, 1'b0},
        '{OP_MUL, R_B,  R_B,  R_P1, 1'b0},
        '{OP_MUL, R_B,  R_A,  R_P2, 1'b0},
        '{OP_SUB, R_P0, R_P1, R_A,  1'b0},
        '{OP_ADD, R_P2, R_P2, R_B,  1'b0}
    };

    function automatic logic is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

endpackage

// File: hw/rtl/cfip_fpu.sv
module cfip_fpu (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  cfip_pkg::fp_op_t    op,
    input  logic [31:0]         a,
    input  logic [31:0]         b,
    output logic                done,
    output logic [31:0]         result
);
    import cfip_pkg::*;

    fpu_state_t state_reg, state_next;

    logic [SIG_W-1:0]         sig_reg;
    logic signed [EXPI_W-1:0] e_reg;
    logic                     sticky_reg;
    logic                     sign_reg;
    logic                     effsub_reg;
    logic [23:0]              xm_reg, ym_reg;
    logic signed [EXPI_W-1:0] xe_reg, ye_reg;
    logic [25:0]              rem_reg;
    logic [5:0]               cnt_reg;
    logic [31:0]              res_reg;

    // unpack
    logic [7:0]               ea_f, eb_f;
    logic                     a_zero, b_zero, a_inf, b_inf, any_nan;
    logic [23:0]              ma, mb;
    logic signed [EXPI_W-1:0] ea, eb;
    logic                     sbe, a_big;
    logic                     spec;
    logic [31:0]              spec_val;
    logic [47:0]              prod;

    always_comb
    begin
        ea_f    = a[30:23];
        eb_f    = b[30:23];
        a_zero  = (a[30:0] == 31'd0);
        b_zero  = (b[30:0] == 31'd0);
        a_inf   = (ea_f == 8'hFF) && (a[22:0] == 23'd0);
        b_inf   = (eb_f == 8'hFF) && (b[22:0] == 23'd0);
        any_nan = is_nan(a) || is_nan(b);
        ma      = {ea_f != 8'd0, a[22:0]};
        mb      = {eb_f != 8'd0, b[22:0]};
        ea      = (ea_f == 8'd0) ? 12'sd1 : $signed({4'b0, ea_f});
        eb      = (eb_f == 8'd0) ? 12'sd1 : $signed({4'b0, eb_f});
        sbe     = b[31] ^ (op == OP_SUB);
        a_big   = (a[30:0] >= b[30:0]);
        prod    = ma * mb;
        spec     = 1'b0;
        spec_val = CANON_NAN;
        case (op)
            OP_MUL:
            begin
                if (any_nan || (a_inf && b_zero) || (a_zero && b_inf))
                begin
                    spec = 1'b1;
                end
                else if (a_inf || b_inf)
                begin
                    spec     = 1'b1;
                    spec_val = {a[31] ^ b[31], 8'hFF, 23'd0};
                end
                else if (a_zero || b_zero)
                begin
                    spec     = 1'b1;
                    spec_val = {a[31] ^ b[31], 31'd0};
                end
            end
            OP_DIV:
            begin
                if (any_nan || (a_inf && b_inf) || (a_zero && b_zero))
                begin
                    spec = 1'b1;
                end
                else if (a_inf || b_zero)
                begin
                    spec     = 1'b1;
                    spec_val = {a[31] ^ b[31], 8'hFF, 23'd0};
                end
                else if (a_zero || b_inf)
                begin
                    spec     = 1'b1;
                    spec_val = {a[31] ^ b[31], 31'd0};
                end
            end
            default:
            begin
                if (any_nan || (a_inf && b_inf && (a[31] != sbe)))
                begin
                    spec = 1'b1;
                end
                else if (a_inf)
                begin
                    spec     = 1'b1;
                    spec_val = {a[31], 8'hFF, 23'd0};
                end
                else if (b_inf)
                begin
                    spec     = 1'b1;
                    spec_val = {sbe, 8'hFF, 23'd0};
                end
                else if (a_zero && b_zero)
                begin
                    spec     = 1'b1;
                    spec_val = {a[31] & sbe, 31'd0};
                end
            end
        endcase
    end

    // alignment and add
    logic [EXPI_W-1:0] dsh;
    logic [SIG_W-1:0]  big_sig, small_full, shifted, small_op, sum;
    logic              lost, sum_zero;

    always_comb
    begin
        dsh        = $unsigned(xe_reg - ye_reg);
        big_sig    = {1'b0, xm_reg, 25'd0};
        small_full = {1'b0, ym_reg, 25'd0};
        shifted    = small_full >> dsh;
        lost       = ((shifted << dsh) != small_full);
        small_op   = {shifted[SIG_W-1:1], shifted[0] | lost};
        sum        = effsub_reg ? (big_sig - small_op) : (big_sig + small_op);
        sum_zero   = (sum == '0);
    end

    // restoring divide step
    logic [25:0] ym_ext, r1;
    logic        ge, div_last, pre_done;

    always_comb
    begin
        ym_ext   = {2'b00, ym_reg};
        ge       = (rem_reg >= ym_ext);
        r1       = ge ? (rem_reg - ym_ext) : rem_reg;
        div_last = (cnt_reg == DIV_LAST);
        pre_done = xm_reg[23] && ym_reg[23];
    end

    // normalize and round
    logic              sig_nz, go_left, go_right, norm_done;
    logic [23:0]       mant, mant_f;
    logic [24:0]       r25;
    logic              g, st, inc;
    logic signed [EXPI_W-1:0] e_f;
    logic [31:0]       round_val;

    always_comb
    begin
        sig_nz    = (sig_reg != '0);
        go_left   = !sig_reg[SIG_W-1] && sig_nz && (e_reg > 12'sd1);
        go_right  = (e_reg < 12'sd1) && sig_nz;
        norm_done = !go_left && !go_right;
        mant      = sig_reg[SIG_W-1:SIG_W-24];
        g         = sig_reg[SIG_W-25];
        st        = (sig_reg[SIG_W-26:0] != '0) || sticky_reg;
        inc       = g && (st || mant[0]);
        r25       = {1'b0, mant} + {24'd0, inc};
        if (r25[24])
        begin
            mant_f = r25[24:1];
            e_f    = e_reg + 12'sd1;
        end
        else
        begin
            mant_f = r25[23:0];
            e_f    = e_reg;
        end
        if (!mant_f[23])
        begin
            round_val = {sign_reg, 8'd0, mant_f[22:0]};
        end
        else if (e_f >= 12'sd255)
        begin
            round_val = {sign_reg, 8'hFF, 23'd0};
        end
        else
        begin
            round_val = {sign_reg, e_f[7:0], mant_f[22:0]};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    if (spec)
                    begin
                        state_next = F_DONE;
                    end
                    else if (op == OP_MUL)
                    begin
                        state_next = F_NORM;
                    end
                    else if (op == OP_DIV)
                    begin
                        state_next = F_PRENORM;
                    end
                    else
                    begin
                        state_next = F_ALIGN;
                    end
                end
            end
            F_ALIGN:   state_next = sum_zero ? F_DONE : F_NORM;
            F_PRENORM: state_next = pre_done ? F_DIV : F_PRENORM;
            F_DIV:     state_next = div_last ? F_NORM : F_DIV;
            F_NORM:    state_next = norm_done ? F_DONE : F_NORM;
            F_DONE:    state_next = F_IDLE;
            default:   state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    res_reg    <= spec_val;
                    sticky_reg <= 1'b0;
                    sign_reg   <= a[31] ^ b[31];
                    effsub_reg <= (a[31] != sbe);
                    if (op == OP_MUL)
                    begin
                        sig_reg <= {prod, 2'b00};
                        e_reg   <= ea + eb - 12'sd126;
                    end
                    else if (op == OP_DIV)
                    begin
                        xm_reg <= ma;
                        ym_reg <= mb;
                        xe_reg <= ea;
                        ye_reg <= eb;
                    end
                    else if (a_big)
                    begin
                        xm_reg   <= ma;
                        ym_reg   <= mb;
                        xe_reg   <= ea;
                        ye_reg   <= eb;
                        sign_reg <= a[31];
                    end
                    else
                    begin
                        xm_reg   <= mb;
                        ym_reg   <= ma;
                        xe_reg   <= eb;
                        ye_reg   <= ea;
                        sign_reg <= sbe;
                    end
                end
            end
            F_ALIGN:
            begin
                sig_reg <= sum;
                e_reg   <= xe_reg + 12'sd1;
                res_reg <= FP_ZERO;
            end
            F_PRENORM:
            begin
                if (!xm_reg[23])
                begin
                    xm_reg <= {xm_reg[22:0], 1'b0};
                    xe_reg <= xe_reg - 12'sd1;
                end
                else if (!ym_reg[23])
                begin
                    ym_reg <= {ym_reg[22:0], 1'b0};
                    ye_reg <= ye_reg - 12'sd1;
                end
                else
                begin
                    rem_reg <= {2'b00, xm_reg};
                    e_reg   <= xe_reg - ye_reg + 12'sd128;
                    cnt_reg <= 6'd0;
                    sig_reg <= '0;
                end
            end
            F_DIV:
            begin
                sig_reg    <= {sig_reg[SIG_W-2:0], ge};
                rem_reg    <= {r1[24:0], 1'b0};
                cnt_reg    <= cnt_reg + 6'd1;
                sticky_reg <= (r1 != 26'd0);
            end
            F_NORM:
            begin
                if (go_left)
                begin
                    sig_reg <= {sig_reg[SIG_W-2:0], 1'b0};
                    e_reg   <= e_reg - 12'sd1;
                end
                else if (go_right)
                begin
                    sticky_reg <= sticky_reg | sig_reg[0];
                    sig_reg    <= {1'b0, sig_reg[SIG_W-1:1]};
                    e_reg      <= e_reg + 12'sd1;
                end
                else
                begin
                    res_reg <= round_val;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done   = (state_reg == F_DONE);
    assign result = res_reg;

endmodule

// File: hw/rtl/cfip_datapath.sv
module cfip_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cfip_pkg::cmd_t                     cmd,
    output cfip_pkg::stat_t                    stat,
    input  logic [31:0]                        base_real,
    input  logic [31:0]                        base_imag,
    input  logic signed [cfip_pkg::EXP_WIDTH-1:0] exponent,
    output logic [31:0]                        result_real,
    output logic [31:0]                        result_imag
);
    import cfip_pkg::*;

    logic [31:0] a_reg, b_reg, re_reg, im_reg;
    logic [31:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic [31:0] res_re_reg, res_im_reg;
    logic [EXP_WIDTH-1:0] mag_reg;
    logic                 neg_reg;

    logic [EXP_WIDTH-1:0] x_in, mag_in;
    logic [31:0] op_a, op_b, fpu_a, fpu_res;
    logic        fpu_done;

    function automatic logic [31:0] pick(
        input reg_sel_t s,
        input logic [31:0] va, input logic [31:0] vb,
        input logic [31:0] vre, input logic [31:0] vim,
        input logic [31:0] v0, input logic [31:0] v1,
        input logic [31:0] v2, input logic [31:0] v3
    );
        logic [31:0] v;
        case (s)
            R_A:     v = va;
            R_B:     v = vb;
            R_RE:    v = vre;
            R_IM:    v = vim;
            R_P0:    v = v0;
            R_P1:    v = v1;
            R_P2:    v = v2;
            R_P3:    v = v3;
            default: v = va;
        endcase
        return v;
    endfunction

    always_comb
    begin
        x_in   = $unsigned(exponent[EXP_WIDTH-1:0]);
        mag_in = x_in[EXP_WIDTH-1] ? (~x_in + {{(EXP_WIDTH-1){1'b0}}, 1'b1}) : x_in;
        op_a   = pick(cmd.uop.src_a, a_reg, b_reg, re_reg, im_reg,
                      p0_reg, p1_reg, p2_reg, p3_reg);
        op_b   = pick(cmd.uop.src_b, a_reg, b_reg, re_reg, im_reg,
                      p0_reg, p1_reg, p2_reg, p3_reg);
        fpu_a  = cmd.uop.neg_a ? {~op_a[31], op_a[30:0]} : op_a;
    end

    cfip_fpu u_fpu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.issue),
        .op     (cmd.uop.op),
        .a      (fpu_a),
        .b      (op_b),
        .done   (fpu_done),
        .result (fpu_res)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg   <= base_real;
            b_reg   <= base_imag;
            re_reg  <= FP_ONE;
            im_reg  <= FP_ZERO;
            neg_reg <= x_in[EXP_WIDTH-1];
            mag_reg <= mag_in;
        end
        else
        begin
            if (cmd.shift)
            begin
                mag_reg <= {1'b0, mag_reg[EXP_WIDTH-1:1]};
            end
            if (fpu_done)
            begin
                case (cmd.uop.dst)
                    R_A:     a_reg  <= fpu_res;
                    R_B:     b_reg  <= fpu_res;
                    R_RE:    re_reg <= fpu_res;
                    R_IM:    im_reg <= fpu_res;
                    R_P0:    p0_reg <= fpu_res;
                    R_P1:    p1_reg <= fpu_res;
                    R_P2:    p2_reg <= fpu_res;
                    R_P3:    p3_reg <= fpu_res;
                    default: p0_reg <= fpu_res;
                endcase
            end
        end
        if (cmd.capture)
        begin
            res_re_reg <= is_nan(re_reg) ? CANON_NAN : re_reg;
            res_im_reg <= is_nan(im_reg) ? CANON_NAN : im_reg;
        end
    end

    always_comb
    begin
        stat.fpu_done = fpu_done;
        stat.mag_zero = (mag_reg == '0);
        stat.mag_lsb  = mag_reg[0];
        stat.mag_one  = (mag_reg == {{(EXP_WIDTH-1){1'b0}}, 1'b1});
        stat.neg      = neg_reg;
    end

    assign result_real = res_re_reg;
    assign result_imag = res_im_reg;

endmodule

// File: hw/rtl/cfip_ctrl.sv
module cfip_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output cfip_pkg::cmd_t  cmd,
    input  cfip_pkg::stat_t stat
);
    import cfip_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic [3:0]  pc_reg, pc_next;
    logic        out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = C_START;
                end
            end
            C_START:
            begin
                if (stat.neg)
                begin
                    pc_next    = RECIP_START;
                    state_next = C_ISSUE;
                end
                else
                begin
                    state_next = C_BIT;
                end
            end
            C_BIT:
            begin
                if (stat.mag_zero)
                begin
                    state_next = C_OUT;
                end
                else if (stat.mag_lsb)
                begin
                    pc_next    = MUL_START;
                    state_next = C_ISSUE;
                end
                else
                begin
                    state_next = C_SQ;
                end
            end
            C_SQ:
            begin
                if (stat.mag_one)
                begin
                    state_next = C_OUT;
                end
                else
                begin
                    pc_next    = SQ_START;
                    state_next = C_ISSUE;
                end
            end
            C_ISSUE:
            begin
                state_next = C_WAIT;
            end
            C_WAIT:
            begin
                if (stat.fpu_done)
                begin
                    if (pc_reg inside {RECIP_END, SQ_END})
                    begin
                        state_next = C_BIT;
                    end
                    else if (pc_reg == MUL_END)
                    begin
                        state_next = C_SQ;
                    end
                    else
                    begin
                        pc_next    = pc_reg + 4'd1;
                        state_next = C_ISSUE;
                    end
                end
            end
            C_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = (state_reg == C_IDLE);
        cmd.load    = (state_reg == C_IDLE) && in_valid;
        cmd.issue   = (state_reg == C_ISSUE);
        cmd.shift   = (state_reg == C_WAIT) && stat.fpu_done && (pc_reg == SQ_END);
        cmd.capture = (state_reg == C_OUT) && (!out_valid_reg || out_ready);
        cmd.uop     = UOP_TABLE[pc_reg];
        if (cmd.capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_IDLE;
            pc_reg        <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: hw/rtl/complex_float_integer_power.sv
// Complex power of a single-precision base by a signed integer exponent.
// Input channel: in_valid/in_ready with base_real, base_imag (binary32
// patterns) and exponent (two's complement). Output channel:
// out_valid/out_ready with result_real, result_imag; any NaN comes out
// as 0x7FC00000.
// One item is worked on at a time; in_ready is high only while idle.
// After setup, a negative exponent first forms the reciprocal of the
// base with two divides; then each exponent bit up to the top set bit
// multiplies the base into the result if set and squares the base,
// except at the top set bit; exponent zero goes straight to the output.
// Each add, multiply and divide runs on one shared iterative FPU;
// subnormal and cancellation cases add normalization shifts of one
// bit per cycle.
// The result sits in an output register: the next item is accepted while
// it waits, but a finished result is held until the old one is taken.
// Reset clears the sequencer and the output valid; no result is pending.
module complex_float_integer_power (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [31:0]                           base_real,
    input  logic [31:0]                           base_imag,
    input  logic signed [cfip_pkg::EXP_WIDTH-1:0] exponent,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [31:0]                           result_real,
    output logic [31:0]                           result_imag
);
    import cfip_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    cfip_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .base_real   (base_real),
        .base_imag   (base_imag),
        .exponent    (exponent),
        .result_real (result_real),
        .result_imag (result_imag)
    );

    cfip_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a second item back to back");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (!out_valid || out_ready))
        else $error("result overwritten before it was taken");

    a_issue_while_done: assert property (@(posedge clk) disable iff (!rst_n)
        stat.fpu_done |-> !cmd.issue)
        else $error("FPU op issued while previous result retiring");

endmodule

// File: tb/complex_float_integer_power_tb.sv
`timescale 1ns / 100ps

class cpow_scoreboard;
    logic [63:0] pending_q[$];
    int mismatches;
    int matched;

    function new();
        mismatches = 0;
        matched = 0;
    endfunction

    function real sp_to_real(logic [31:0] x);
        logic [63:0] d;
        real r;
        if (x[30:23] == 8'hFF)
        begin
            d = {x[31], 11'h7FF, x[22:0], 29'd0};
            return $bitstoreal(d);
        end
        if (x[30:23] == 8'h00)
        begin
            r = x[22:0];
            r = r * (2.0 ** (-149));
            if (x[31])
                r = -r;
            return r;
        end
        d = {x[31], 11'(x[30:23] + 11'd896), x[22:0], 29'd0};
        return $bitstoreal(d);
    endfunction

    // round a double to binary32, nearest even, subnormals kept
    function logic [31:0] real_to_sp(real r);
        logic [63:0] d;
        logic [63:0] sig;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        logic [31:0] field;
        int e;
        int sh;
        d = $realtobits(r);
        if (d[62:52] == 11'h7FF)
        begin
            if (d[51:0] != 0)
                return cfip_pkg::CANON_NAN;
            return {d[63], 8'hFF, 23'd0};
        end
        if (d[62:52] == 11'd0)
            return {d[63], 31'd0};
        e = int'(d[62:52]) - 1023;
        if (e > 127)
            return {d[63], 8'hFF, 23'd0};
        sig = {11'd1, d[51:0]};
        sh = (e >= -126) ? 29 : 29 + (-126 - e);
        if (sh >= 54)
            return {d[63], 31'd0};
        kept = sig >> sh;
        rem = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0]))
            kept = kept + 1;
        if (e >= -126)
            field = 32'(((e + 127) << 23) + kept - (64'd1 << 23));
        else
            field = kept[31:0];
        return {d[63], field[30:0]};
    endfunction

    function logic [31:0] fmul(logic [31:0] x, logic [31:0] y);
        return real_to_sp(sp_to_real(x) * sp_to_real(y));
    endfunction

    function logic [31:0] fadd(logic [31:0] x, logic [31:0] y);
        return real_to_sp(sp_to_real(x) + sp_to_real(y));
    endfunction

    function logic [31:0] fsub(logic [31:0] x, logic [31:0] y);
        return real_to_sp(sp_to_real(x) - sp_to_real(y));
    endfunction

    function logic [31:0] fdiv(logic [31:0] x, logic [31:0] y);
        return real_to_sp(sp_to_real(x) / sp_to_real(y));
    endfunction

    function logic [63:0] complex_power(logic [31:0] a_in, logic [31:0] b_in,
                                        logic [63:0] ex);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] re;
        logic [31:0] im;
        logic [31:0] t;
        logic [31:0] den;
        logic [63:0] mag;
        a = a_in;
        b = b_in;
        re = cfip_pkg::FP_ONE;
        im = cfip_pkg::FP_ZERO;
        mag = ex;
        if (ex[63])
        begin
            mag = -ex;
            den = fadd(fmul(a, a), fmul(b, b));
            a = fdiv(a_in, den);
            b = fdiv({~b_in[31], b_in[30:0]}, den);
        end
        while (mag != 0)
        begin
            if (mag[0])
            begin
                t = re;
                re = fsub(fmul(t, a), fmul(im, b));
                im = fadd(fmul(im, a), fmul(t, b));
            end
            t = a;
            a = fsub(fmul(a, a), fmul(b, b));
            b = fadd(fmul(b, t), fmul(t, b));
            mag = mag >> 1;
        end
        if (cfip_pkg::is_nan(re))
            re = cfip_pkg::CANON_NAN;
        if (cfip_pkg::is_nan(im))
            im = cfip_pkg::CANON_NAN;
        return {re, im};
    endfunction

    function void note_item(logic [31:0] br, logic [31:0] bi, logic [63:0] ex);
        pending_q.push_back(complex_power(br, bi, ex));
    endfunction

    function void check_result(logic [31:0] rr, logic [31:0] ri);
        logic [63:0] want;
        if (pending_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result re=%h im=%h", rr, ri);
            return;
        end
        want = pending_q.pop_front();
        if (want[63:32] !== rr || want[31:0] !== ri)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: expected re=%h im=%h, got re=%h im=%h",
                         matched + mismatches - 1, want[63:32], want[31:0], rr, ri);
        end
        else
            matched++;
    endfunction
endclass

module complex_float_integer_power_tb;
    localparam int N_RANDOM = 530;
    localparam int CALM_TAIL = 60;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] base_real;
    logic [31:0] base_imag;
    logic signed [cfip_pkg::EXP_WIDTH-1:0] exponent;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] result_real;
    logic [31:0] result_imag;

    cpow_scoreboard sb;
    bit calm;
    int n_items;
    int n_neg;
    int n_wide;

    complex_float_integer_power dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .base_real  (base_real),
        .base_imag  (base_imag),
        .exponent   (exponent),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_real(result_real),
        .result_imag(result_imag)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial
    begin
        sb = new();
        calm = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        base_real = '0;
        base_imag = '0;
        exponent = '0;
        out_ready = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            sb.note_item(base_real, base_imag, exponent);
            n_items++;
            if (exponent < 0)
                n_neg++;
            if (exponent > 64'sd65535 || exponent < -64'sd65536)
                n_wide++;
        end
        if (rst_n && out_valid && out_ready)
            sb.check_result(result_real, result_imag);
    end

    initial
    begin
        int k;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                k = $urandom_range(1, 18);
            end
            else
            begin
                out_ready <= 1'b1;
                k = $urandom_range(1, 30);
            end
            repeat (k) @(posedge clk);
        end
    end

    task automatic send_item(logic [31:0] br, logic [31:0] bi, logic [63:0] ex);
        in_valid <= 1'b1;
        base_real <= br;
        base_imag <= bi;
        exponent <= ex;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] pick_base();
        logic [31:0] specials [10];
        int r;
        specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0001, 32'h0000_0001, 32'h007F_FFFF, 32'h3F80_0000,
                     32'h7F7F_FFFF, 32'hBF80_0000};
        r = $urandom_range(0, 99);
        if (r < 35)
            return {1'($urandom), 8'($urandom_range(125, 128)), 23'($urandom)};
        if (r < 55)
            return $urandom;
        if (r < 70)
            return specials[$urandom_range(0, 9)];
        return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
    endfunction

    function automatic logic [63:0] pick_exponent();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 64'($signed($urandom_range(0, 40)) - 20);
        if (r < 70)
            return 64'($signed($urandom_range(0, 600)) - 300);
        if (r < 88)
            return {{48{1'($urandom)}}, 16'($urandom)};
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        int spins;
        n_items = 0;
        n_neg = 0;
        n_wide = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(32'h3FC0_0000, 32'h4000_0000, 64'd0);
        send_item(32'h3FC0_0000, 32'h4000_0000, 64'd1);
        send_item(32'h3FC0_0000, 32'h4000_0000, -64'd1);
        send_item(32'h0000_0000, 32'h3F80_0000, 64'd7);
        send_item(32'h0000_0000, 32'h0000_0000, -64'd3);
        send_item(32'h8000_0000, 32'h0000_0000, -64'd1);
        send_item(32'h3F80_0000, 32'h0000_0000, 64'h8000_0000_0000_0000);
        send_item(32'h3F80_0000, 32'h8000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(32'hBF80_0000, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(32'h7FC0_0000, 32'h3F80_0000, 64'd2);
        send_item(32'hFFFF_FFFF, 32'h0000_0000, 64'd0);
        send_item(32'h7F80_0000, 32'h0000_0000, 64'd2);
        send_item(32'h7F80_0000, 32'h7F80_0000, -64'd2);
        send_item(32'h0000_0001, 32'h0000_0000, 64'd1);
        send_item(32'h0000_0001, 32'h0000_0001, -64'd1);
        send_item(32'h007F_FFFF, 32'h8000_0001, 64'd3);
        send_item(32'h1F80_0000, 32'h0000_0000, 64'd5);
        send_item(32'h7F7F_FFFF, 32'hFF7F_FFFF, 64'd2);
        send_item(32'h3F80_0001, 32'h3380_0000, 64'd1000003);
        send_item(32'h3F35_04F3, 32'h3F35_04F3, 64'd8);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (sb.pending_q.size() != 0)
                    @(posedge clk);
            end
            if (i == N_RANDOM - CALM_TAIL)
                calm = 1'b1;
            send_item(pick_base(), pick_base(), pick_exponent());
        end
        in_valid <= 1'b0;

        spins = 0;
        while (sb.pending_q.size() != 0 && spins < 2000000)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (300) @(posedge clk);

        $display("%0d items sent (%0d negative powers, %0d wide powers), %0d results matched",
                 n_items, n_neg, n_wide, sb.matched);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("complex_float_integer_power: match");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.pending_q.size());
            $display("complex_float_integer_power: mismatch");
        end
        $finish;
    end

    initial
    begin
        #40ms;
        $display("timeout");
        $display("complex_float_integer_power: mismatch");
        $finish;
    end
endmodule
